FILE: rtl/core/reservation_station_table_macros.svh
// Assertion macros used by the reservation station table checker.
`ifndef RESERVATION_STATION_TABLE_MACROS_SVH
`define RESERVATION_STATION_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSTAB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reservation station table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RSTAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reservation station table: next-cycle check failed");

`endif

FILE: rtl/core/rstab_pkg.sv
// Types and constants of the reservation station table.
package rstab_pkg;

    localparam int CMD_W  = 3;
    localparam int OPC_W  = 6;
    localparam int TAG_W  = 6;
    localparam int VAL_W  = 32;
    localparam int FREE_W = 4;
    localparam int PAY_W  = OPC_W + VAL_W + TAG_W + VAL_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_DISPATCH  = 3'd0,
        CMD_CAPTURE   = 3'd1,
        CMD_ISSUE     = 3'd2,
        CMD_FLUSH     = 3'd3,
        CMD_CYCLE_END = 3'd4
    } rstab_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SWEEP
    } rstab_state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [OPC_W-1:0] opcode;
        logic [TAG_W-1:0] src1_tag;
        logic [TAG_W-1:0] src2_tag;
        logic [VAL_W-1:0] src1_value;
        logic [VAL_W-1:0] src2_value;
        logic [VAL_W-1:0] immediate;
        logic [TAG_W-1:0] dest_tag;
        logic [VAL_W-1:0] instr_pc;
        logic [TAG_W-1:0] bcast_tag;
        logic [VAL_W-1:0] bcast_value;
    } rstab_req_t;

    typedef struct packed {
        logic              dispatch_ok;
        logic              issue_valid;
        logic [OPC_W-1:0]  out_opcode;
        logic [VAL_W-1:0]  out_src1;
        logic [VAL_W-1:0]  out_src2;
        logic [VAL_W-1:0]  out_immediate;
        logic [TAG_W-1:0]  out_dest_tag;
        logic [VAL_W-1:0]  out_pc;
        logic [FREE_W-1:0] free_count;
    } rstab_rsp_t;

    typedef struct packed {
        logic load_req;
        logic exec_dispatch;
        logic exec_capture;
        logic exec_issue;
        logic exec_flush;
        logic exec_cycle_end;
        logic sweep_step;
        logic finish;
        logic finish_issue;
    } rstab_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             issue_found;
        logic             any_match;
        logic             sweep_last;
    } rstab_sts_t;

endpackage

FILE: rtl/core/rstab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rstab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/rstab_ctrl.sv
// Command sequencer of the reservation station table.
module rstab_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    input  rstab_pkg::rstab_sts_t sts,
    output rstab_pkg::rstab_ctl_t ctl
);

    rstab_pkg::rstab_state_t state_reg, state_next;
    logic                    done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rstab_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            rstab_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = rstab_pkg::ST_EXEC;
                end
            end
            rstab_pkg::ST_EXEC:
            begin
                case (sts.cmd)
                    rstab_pkg::CMD_DISPATCH:
                    begin
                        ctl.exec_dispatch = 1'b1;
                        ctl.finish        = 1'b1;
                        state_next        = rstab_pkg::ST_IDLE;
                    end
                    rstab_pkg::CMD_CAPTURE:
                    begin
                        ctl.exec_capture = 1'b1;
                        if (sts.any_match)
                        begin
                            state_next = rstab_pkg::ST_SWEEP;
                        end
                        else
                        begin
                            ctl.finish = 1'b1;
                            state_next = rstab_pkg::ST_IDLE;
                        end
                    end
                    rstab_pkg::CMD_ISSUE:
                    begin
                        ctl.exec_issue = 1'b1;
                        if (sts.issue_found)
                        begin
                            state_next = rstab_pkg::ST_READ;
                        end
                        else
                        begin
                            ctl.finish = 1'b1;
                            state_next = rstab_pkg::ST_IDLE;
                        end
                    end
                    rstab_pkg::CMD_FLUSH:
                    begin
                        ctl.exec_flush = 1'b1;
                        ctl.finish     = 1'b1;
                        state_next     = rstab_pkg::ST_IDLE;
                    end
                    rstab_pkg::CMD_CYCLE_END:
                    begin
                        ctl.exec_cycle_end = 1'b1;
                        ctl.finish         = 1'b1;
                        state_next         = rstab_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                        state_next = rstab_pkg::ST_IDLE;
                    end
                endcase
            end
            rstab_pkg::ST_READ:
            begin
                // The payload memories return the selected entry in this cycle.
                ctl.finish_issue = 1'b1;
                ctl.finish       = 1'b1;
                state_next       = rstab_pkg::ST_IDLE;
            end
            rstab_pkg::ST_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    ctl.finish = 1'b1;
                    state_next = rstab_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rstab_pkg::ST_IDLE;
            end
        endcase
        done_next = ctl.finish;
    end

    assign busy = (state_reg != rstab_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

FILE: rtl/core/rstab_dp.sv
// Entry state, operand memories and result register of the reservation station table.
module rstab_dp #(
    parameter int NUM_ENTRIES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rstab_pkg::rstab_req_t request,
    input  rstab_pkg::rstab_ctl_t ctl,
    output rstab_pkg::rstab_sts_t sts,
    output rstab_pkg::rstab_rsp_t result
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);
    localparam logic [CW-1:0] ALL_FREE = CW'(NUM_ENTRIES);

    rstab_pkg::rstab_req_t   req_reg;
    rstab_pkg::rstab_rsp_t   result_reg, result_next;

    logic [NUM_ENTRIES-1:0]  busy_vis_reg;
    logic [NUM_ENTRIES-1:0]  busy_pend_reg;
    logic [NUM_ENTRIES-1:0]  ready_vis_reg, ready_vis_next;
    logic [NUM_ENTRIES-1:0]  alloc_reg;
    logic [NUM_ENTRIES-1:0]  issued_reg;
    logic [NUM_ENTRIES-1:0]  m1_reg, m2_reg;
    logic [NUM_ENTRIES-1:0]  match1, match2;
    logic [NUM_ENTRIES-1:0]  free_mask, ready_mask;
    logic [rstab_pkg::TAG_W-1:0] tag1_reg [NUM_ENTRIES];
    logic [rstab_pkg::TAG_W-1:0] tag2_reg [NUM_ENTRIES];
    logic [CW-1:0]           pend_free_reg, vis_free_reg, vis_free_next;
    logic [CW+rstab_pkg::FREE_W-1:0] free_ext;
    logic [IW-1:0]           sweep_idx_reg;
    logic [IW-1:0]           disp_idx, issue_idx;
    logic                    disp_found, issue_found;
    logic                    disp_we;

    logic                          val1_we, val2_we;
    logic [IW-1:0]                 val_waddr;
    logic [rstab_pkg::VAL_W-1:0]   val1_wdata, val2_wdata;
    logic [rstab_pkg::VAL_W-1:0]   val1_rdata, val2_rdata;
    logic [rstab_pkg::PAY_W-1:0]   pay_wdata, pay_rdata;

    // Selection works against the copy visible since the last cycle boundary,
    // skipping entries already handed out in the current cycle.
    assign free_mask  = ~busy_vis_reg & ~alloc_reg;
    assign ready_mask = busy_vis_reg & ready_vis_reg & ~issued_reg;

    always_comb
    begin
        disp_found = 1'b0;
        disp_idx   = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                disp_found = 1'b1;
                disp_idx   = IW'(i);
            end
        end
    end

    always_comb
    begin
        issue_found = 1'b0;
        issue_idx   = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (ready_mask[i])
            begin
                issue_found = 1'b1;
                issue_idx   = IW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            match1[i] = busy_pend_reg[i] && (tag1_reg[i] == req_reg.bcast_tag)
                        && (req_reg.bcast_tag != '0);
            match2[i] = busy_pend_reg[i] && (tag2_reg[i] == req_reg.bcast_tag)
                        && (req_reg.bcast_tag != '0);
            ready_vis_next[i] = busy_pend_reg[i] && (tag1_reg[i] == '0)
                                && (tag2_reg[i] == '0);
        end
    end

    assign disp_we = ctl.exec_dispatch && disp_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_vis_reg  <= '0;
            busy_pend_reg <= '0;
            ready_vis_reg <= '0;
            alloc_reg     <= '0;
            issued_reg    <= '0;
            m1_reg        <= '0;
            m2_reg        <= '0;
            pend_free_reg <= ALL_FREE;
            vis_free_reg  <= ALL_FREE;
            sweep_idx_reg <= '0;
        end
        else
        begin
            if (disp_we)
            begin
                busy_pend_reg[disp_idx] <= 1'b1;
                alloc_reg[disp_idx]     <= 1'b1;
                pend_free_reg           <= pend_free_reg - CW'(1);
            end
            if (ctl.exec_issue && issue_found)
            begin
                // A flushed entry is already free in the pending copy.
                busy_pend_reg[issue_idx] <= 1'b0;
                issued_reg[issue_idx]    <= 1'b1;
                pend_free_reg <= pend_free_reg + CW'(busy_pend_reg[issue_idx]);
            end
            if (ctl.exec_flush)
            begin
                busy_pend_reg <= '0;
                pend_free_reg <= ALL_FREE;
            end
            if (ctl.exec_cycle_end)
            begin
                busy_vis_reg  <= busy_pend_reg;
                ready_vis_reg <= ready_vis_next;
                alloc_reg     <= '0;
                issued_reg    <= '0;
                vis_free_reg  <= pend_free_reg;
            end
            if (ctl.exec_capture)
            begin
                m1_reg        <= match1;
                m2_reg        <= match2;
                sweep_idx_reg <= '0;
            end
            if (ctl.sweep_step)
            begin
                sweep_idx_reg <= sweep_idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_reg <= request;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (disp_we && (disp_idx == IW'(i)))
            begin
                tag1_reg[i] <= req_reg.src1_tag;
                tag2_reg[i] <= req_reg.src2_tag;
            end
            if (ctl.exec_capture && match1[i])
            begin
                tag1_reg[i] <= '0;
            end
            if (ctl.exec_capture && match2[i])
            begin
                tag2_reg[i] <= '0;
            end
        end
        if (ctl.finish)
        begin
            result_reg <= result_next;
        end
    end

    // The capture sweep writes the broadcast value into every matched operand,
    // one entry per beat; tags were already cleared when the sweep began.
    assign val_waddr  = ctl.sweep_step ? sweep_idx_reg : disp_idx;
    assign val1_we    = disp_we || (ctl.sweep_step && m1_reg[sweep_idx_reg]);
    assign val2_we    = disp_we || (ctl.sweep_step && m2_reg[sweep_idx_reg]);
    assign val1_wdata = ctl.sweep_step ? req_reg.bcast_value : req_reg.src1_value;
    assign val2_wdata = ctl.sweep_step ? req_reg.bcast_value : req_reg.src2_value;
    assign pay_wdata  = {req_reg.opcode, req_reg.immediate, req_reg.dest_tag, req_reg.instr_pc};

    rstab_ram #(
        .WIDTH(rstab_pkg::PAY_W),
        .DEPTH(NUM_ENTRIES)
    ) u_pay_ram (
        .clk  (clk),
        .we   (disp_we),
        .waddr(disp_idx),
        .wdata(pay_wdata),
        .raddr(issue_idx),
        .rdata(pay_rdata)
    );

    rstab_ram #(
        .WIDTH(rstab_pkg::VAL_W),
        .DEPTH(NUM_ENTRIES)
    ) u_val1_ram (
        .clk  (clk),
        .we   (val1_we),
        .waddr(val_waddr),
        .wdata(val1_wdata),
        .raddr(issue_idx),
        .rdata(val1_rdata)
    );

    rstab_ram #(
        .WIDTH(rstab_pkg::VAL_W),
        .DEPTH(NUM_ENTRIES)
    ) u_val2_ram (
        .clk  (clk),
        .we   (val2_we),
        .waddr(val_waddr),
        .wdata(val2_wdata),
        .raddr(issue_idx),
        .rdata(val2_rdata)
    );

    assign vis_free_next = ctl.exec_cycle_end ? pend_free_reg : vis_free_reg;
    assign free_ext      = {{rstab_pkg::FREE_W{1'b0}}, vis_free_next};

    always_comb
    begin
        result_next             = '0;
        result_next.dispatch_ok = disp_we;
        if (ctl.finish_issue)
        begin
            result_next.issue_valid = 1'b1;
            {result_next.out_opcode, result_next.out_immediate,
             result_next.out_dest_tag, result_next.out_pc} = pay_rdata;
            result_next.out_src1 = val1_rdata;
            result_next.out_src2 = val2_rdata;
        end
        result_next.free_count = free_ext[rstab_pkg::FREE_W-1:0];
    end

    assign sts.cmd         = req_reg.cmd;
    assign sts.issue_found = issue_found;
    assign sts.any_match   = |(match1 | match2);
    assign sts.sweep_last  = (sweep_idx_reg == LAST_IDX);

    assign result = result_reg;

endmodule

FILE: rtl/core/reservation_station_table.sv
// Dispatch, flush, cycle_end and unknown codes finish in the execute state, then show done.
// Issue adds a read state when an entry is found (one registered read of the payload memories).
// With a match, capture also sweeps all entries, one a cycle, writing matched operands.
// One command at a time; start is taken again in the cycle done is shown.
// Asynchronous active-low reset empties the table at once, with no clearing pass.
module reservation_station_table #(
    parameter int NUM_ENTRIES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rstab_pkg::rstab_req_t request,
    output logic                  done,
    output rstab_pkg::rstab_rsp_t result
);

    rstab_pkg::rstab_ctl_t ctl;
    rstab_pkg::rstab_sts_t sts;

    rstab_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .done (done),
        .sts  (sts),
        .ctl  (ctl)
    );

    rstab_dp #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .ctl    (ctl),
        .sts    (sts),
        .result (result)
    );

endmodule

FILE: rtl/core/rstab_checker.sv
// Port-level checks of the reservation station table and their binding.
`include "reservation_station_table_macros.svh"

module rstab_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input rstab_pkg::rstab_rsp_t result
);

    logic issue_fields_zero;

    assign issue_fields_zero = (result.out_opcode == '0) && (result.out_src1 == '0)
                               && (result.out_src2 == '0) && (result.out_immediate == '0)
                               && (result.out_dest_tag == '0) && (result.out_pc == '0);

    `RSTAB_ASSERT_NOW(a_one_kind, done, !(result.dispatch_ok && result.issue_valid))
    `RSTAB_ASSERT_NOW(a_quiet_fields, done && !result.issue_valid, issue_fields_zero)
    `RSTAB_ASSERT_NOW(a_done_idle, done, !busy)
    `RSTAB_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)

endmodule

bind reservation_station_table rstab_checker u_rstab_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

FILE: sim/tb_top.sv
// Self-checking testbench for reservation_station_table: a directed script, then random traffic.
module tb_top;
    import rstab_pkg::*;

    localparam int RS_DEPTH        = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = RS_DEPTH + 4;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int SCRIPT_LEN      = 25;
    localparam int MAX_REPORTS     = 10;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [TAG_W-1:0] tag1;
        logic [TAG_W-1:0] tag2;
        logic [VAL_W-1:0] val1;
        logic [VAL_W-1:0] val2;
        logic [VAL_W-1:0] imm;
        logic [TAG_W-1:0] dest;
        logic [VAL_W-1:0] pc;
    } rs_slot_t;

    typedef struct {
        rstab_req_t req;
        bit         typed;
        rstab_rsp_t rsp;
    } script_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    rstab_req_t request;
    rstab_rsp_t result;

    // Shadow of the table: the copy seen at the last boundary and the one being built.
    bit          busy_now  [RS_DEPTH];
    bit          busy_next [RS_DEPTH];
    bit          ready_now [RS_DEPTH];
    rs_slot_t    slot      [RS_DEPTH];
    int unsigned dispatched_this_cycle;
    int unsigned issued_this_cycle;

    rstab_rsp_t  awaited_rsp[$];
    int unsigned mismatch_count;
    int unsigned stall_cycles;
    script_row_t script [SCRIPT_LEN];
    int          idle_pct [4] = '{0, 74, 0, 12};

    reservation_station_table #(
        .NUM_ENTRIES(RS_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic rstab_req_t make_req(
        input logic [CMD_W-1:0] cmd,
        input logic [OPC_W-1:0] opcode,
        input logic [TAG_W-1:0] t1,
        input logic [TAG_W-1:0] t2,
        input logic [VAL_W-1:0] v1,
        input logic [VAL_W-1:0] v2,
        input logic [VAL_W-1:0] imm,
        input logic [TAG_W-1:0] dest,
        input logic [VAL_W-1:0] pc,
        input logic [TAG_W-1:0] btag,
        input logic [VAL_W-1:0] bval
    );
        rstab_req_t r;
        r.cmd         = cmd;
        r.opcode      = opcode;
        r.src1_tag    = t1;
        r.src2_tag    = t2;
        r.src1_value  = v1;
        r.src2_value  = v2;
        r.immediate   = imm;
        r.dest_tag    = dest;
        r.instr_pc    = pc;
        r.bcast_tag   = btag;
        r.bcast_value = bval;
        return r;
    endfunction

    function automatic rstab_rsp_t answer(input logic ok, input logic iv,
                                          input logic [FREE_W-1:0] free_n);
        rstab_rsp_t a;
        a = '0;
        a.dispatch_ok = ok;
        a.issue_valid = iv;
        a.free_count  = free_n;
        return a;
    endfunction

    // Applies one command to the shadow table and returns the beat the block should answer.
    function automatic rstab_rsp_t rs_table_step(input rstab_req_t r);
        rstab_rsp_t        rsp;
        int unsigned       skip;
        bit                found;
        logic [FREE_W-1:0] free_n;
        rsp   = '0;
        found = 1'b0;
        case (r.cmd)
            CMD_DISPATCH:
            begin
                skip = dispatched_this_cycle;
                for (int i = 0; i < RS_DEPTH; i++)
                begin
                    if (!found && !busy_now[i])
                    begin
                        if (skip != 0)
                            skip = skip - 1;
                        else
                        begin
                            found        = 1'b1;
                            busy_next[i] = 1'b1;
                            slot[i] = '{opcode: r.opcode, tag1: r.src1_tag, tag2: r.src2_tag,
                                        val1: r.src1_value, val2: r.src2_value,
                                        imm: r.immediate, dest: r.dest_tag, pc: r.instr_pc};
                            dispatched_this_cycle++;
                        end
                    end
                end
                rsp.dispatch_ok = found;
            end
            CMD_CAPTURE:
            begin
                // A zero tag on the bus never wakes anything up.
                if (r.bcast_tag != '0)
                begin
                    for (int i = 0; i < RS_DEPTH; i++)
                    begin
                        if (busy_next[i])
                        begin
                            if (slot[i].tag1 == r.bcast_tag)
                            begin
                                slot[i].val1 = r.bcast_value;
                                slot[i].tag1 = '0;
                            end
                            if (slot[i].tag2 == r.bcast_tag)
                            begin
                                slot[i].val2 = r.bcast_value;
                                slot[i].tag2 = '0;
                            end
                        end
                    end
                end
            end
            CMD_ISSUE:
            begin
                skip = issued_this_cycle;
                for (int i = 0; i < RS_DEPTH; i++)
                begin
                    if (!found && busy_now[i] && ready_now[i])
                    begin
                        if (skip != 0)
                            skip = skip - 1;
                        else
                        begin
                            found             = 1'b1;
                            busy_next[i]      = 1'b0;
                            rsp.out_opcode    = slot[i].opcode;
                            rsp.out_src1      = slot[i].val1;
                            rsp.out_src2      = slot[i].val2;
                            rsp.out_immediate = slot[i].imm;
                            rsp.out_dest_tag  = slot[i].dest;
                            rsp.out_pc        = slot[i].pc;
                            issued_this_cycle++;
                        end
                    end
                end
                rsp.issue_valid = found;
            end
            CMD_FLUSH:
            begin
                for (int i = 0; i < RS_DEPTH; i++)
                    busy_next[i] = 1'b0;
            end
            CMD_CYCLE_END:
            begin
                for (int i = 0; i < RS_DEPTH; i++)
                begin
                    busy_now[i]  = busy_next[i];
                    ready_now[i] = busy_next[i] && slot[i].tag1 == '0 && slot[i].tag2 == '0;
                end
                dispatched_this_cycle = 0;
                issued_this_cycle     = 0;
            end
            default:
            begin
            end
        endcase
        free_n = '0;
        for (int i = 0; i < RS_DEPTH; i++)
            free_n = free_n + (busy_now[i] ? 1'b0 : 1'b1);
        rsp.free_count = free_n;
        return rsp;
    endfunction

    // Random command, biased so that broadcasts mostly hit operands that are still waiting.
    function automatic rstab_req_t random_request();
        rstab_req_t       r;
        logic [TAG_W-1:0] live[$];
        int unsigned      pick;
        for (int i = 0; i < RS_DEPTH; i++)
        begin
            if (busy_next[i] && slot[i].tag1 != '0)
                live.push_back(slot[i].tag1);
            if (busy_next[i] && slot[i].tag2 != '0)
                live.push_back(slot[i].tag2);
        end
        r.opcode      = $urandom_range(2**OPC_W - 1);
        r.src1_tag    = ($urandom_range(1) == 0) ? 0 : $urandom_range(32, 1);
        r.src2_tag    = ($urandom_range(1) == 0) ? 0 : $urandom_range(32, 1);
        r.src1_value  = $urandom;
        r.src2_value  = $urandom;
        r.immediate   = $urandom;
        r.dest_tag    = $urandom_range(32, 1);
        r.instr_pc    = $urandom;
        r.bcast_value = $urandom;
        pick = $urandom_range(99);
        if (pick < 2)
            r.bcast_tag = '0;
        else if (live.size() != 0 && pick < 72)
            r.bcast_tag = live[$urandom_range(live.size() - 1)];
        else
            r.bcast_tag = $urandom_range(32, 1);
        pick = $urandom_range(99);
        if (pick < 30)
            r.cmd = CMD_DISPATCH;
        else if (pick < 50)
            r.cmd = CMD_CAPTURE;
        else if (pick < 72)
            r.cmd = CMD_ISSUE;
        else if (pick < 90)
            r.cmd = CMD_CYCLE_END;
        else if (pick < 95)
            r.cmd = CMD_FLUSH;
        else
            r.cmd = $urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO);
        return r;
    endfunction

    // Holds the beat until it is taken, then records what must come back for it.
    task automatic send_beat(input rstab_req_t r, input bit typed, input rstab_rsp_t typed_rsp);
        rstab_rsp_t predicted;
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        predicted = rs_table_step(r);
        awaited_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    always @(posedge clk)
    begin
        rstab_rsp_t want;
        if (rst_n && done)
        begin
            if (awaited_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat: %h", result);
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (result.dispatch_ok !== want.dispatch_ok ||
                    result.issue_valid !== want.issue_valid ||
                    result.out_opcode !== want.out_opcode ||
                    result.out_src1 !== want.out_src1 ||
                    result.out_src2 !== want.out_src2 ||
                    result.out_immediate !== want.out_immediate ||
                    result.out_dest_tag !== want.out_dest_tag ||
                    result.out_pc !== want.out_pc ||
                    result.free_count !== want.free_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("result mismatch: ok/iv/opc/src1/src2/imm/dest/pc/free");
                        $display("  expected %b %b %h %h %h %h %h %h %0d",
                                 want.dispatch_ok, want.issue_valid, want.out_opcode,
                                 want.out_src1, want.out_src2, want.out_immediate,
                                 want.out_dest_tag, want.out_pc, want.free_count);
                        $display("  got      %b %b %h %h %h %h %h %h %0d",
                                 result.dispatch_ok, result.issue_valid, result.out_opcode,
                                 result.out_src1, result.out_src2, result.out_immediate,
                                 result.out_dest_tag, result.out_pc, result.free_count);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;

        // Empty table, a zero-tag broadcast and an unknown code.
        script[0]  = '{make_req(CMD_ISSUE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, answer(0, 0, 8)};
        script[1]  = '{make_req(CMD_CAPTURE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hDEAD_BEEF),
                       1'b1, answer(0, 0, 8)};
        script[2]  = '{make_req(CMD_UNKNOWN_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                       1'b1, answer(0, 0, 8)};
        // Fill all eight entries before the next cycle end, field extremes first.
        script[3]  = '{make_req(CMD_DISPATCH, 63, 0, 0, '1, '1, '1, 32, '1, 32, '1),
                       1'b1, answer(1, 0, 8)};
        script[4]  = '{make_req(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
                       1'b1, answer(1, 0, 8)};
        script[5]  = '{make_req(CMD_DISPATCH, 21, 32, 0, 32'h1111_1111, 32'h2222_2222,
                                32'h3333_3333, 7, 32'h0000_1000, 0, 0), 1'b1, answer(1, 0, 8)};
        script[6]  = '{make_req(CMD_DISPATCH, 22, 0, 32, 32'h4444_4444, 32'h5555_5555,
                                32'h6666_6666, 8, 32'h0000_1004, 0, 0), 1'b1, answer(1, 0, 8)};
        script[7]  = '{make_req(CMD_DISPATCH, 23, 5, 5, 32'h7777_7777, 32'h8888_8888,
                                32'h9999_9999, 9, 32'h0000_1008, 0, 0), 1'b1, answer(1, 0, 8)};
        script[8]  = '{make_req(CMD_DISPATCH, 24, 0, 0, 32'hAAAA_0001, 32'hBBBB_0001,
                                32'hCCCC_0001, 10, 32'h0000_100C, 0, 0), 1'b1, answer(1, 0, 8)};
        script[9]  = '{make_req(CMD_DISPATCH, 25, 0, 0, 32'hAAAA_0002, 32'hBBBB_0002,
                                32'hCCCC_0002, 11, 32'h0000_1010, 0, 0), 1'b1, answer(1, 0, 8)};
        script[10] = '{make_req(CMD_DISPATCH, 26, 0, 0, 32'hAAAA_0003, 32'hBBBB_0003,
                                32'hCCCC_0003, 12, 32'h0000_1014, 0, 0), 1'b1, answer(1, 0, 8)};
        // Ninth dispatch in the same cycle has nowhere to go.
        script[11] = '{make_req(CMD_DISPATCH, 27, 0, 0, 1, 2, 3, 13, 4, 0, 0),
                       1'b1, answer(0, 0, 8)};
        script[12] = '{make_req(CMD_CYCLE_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                       1'b1, answer(0, 0, 0)};
        script[13] = '{make_req(CMD_DISPATCH, 28, 0, 0, 5, 6, 7, 14, 8, 0, 0),
                       1'b1, answer(0, 0, 0)};
        // Tag 32 wakes two operands in different entries; tag 5 wakes both of one entry.
        script[14] = '{make_req(CMD_CAPTURE, 0, 0, 0, 0, 0, 0, 0, 0, 32, 32'hA5A5_A5A5),
                       1'b1, answer(0, 0, 0)};
        script[15] = '{make_req(CMD_CAPTURE, 0, 0, 0, 0, 0, 0, 0, 0, 5, 32'h5A5A_5A5A),
                       1'b1, answer(0, 0, 0)};
        script[16] = '{make_req(CMD_ISSUE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        script[17] = '{make_req(CMD_ISSUE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        // Entries that were ready at the boundary still issue after a flush.
        script[18] = '{make_req(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, answer(0, 0, 0)};
        script[19] = '{make_req(CMD_ISSUE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        script[20] = '{make_req(CMD_CYCLE_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                       1'b1, answer(0, 0, 8)};
        script[21] = '{make_req(CMD_ISSUE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, answer(0, 0, 8)};
        script[22] = '{make_req(CMD_DISPATCH, 42, 0, 0, 32'hCAFE_0000, 32'h0000_CAFE,
                                32'h1234_5678, 20, 32'h8000_0000, 0, 0), 1'b1, answer(1, 0, 8)};
        script[23] = '{make_req(CMD_CYCLE_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                       1'b1, answer(0, 0, 7)};
        script[24] = '{make_req(CMD_ISSUE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
            send_beat(script[k].req, script[k].typed, script[k].rsp);

        // The third phase would stall the receiver, which this block cannot do,
        // so the sender runs at full rate there.
        for (int phase = 0; phase < 4; phase++)
        begin
            start <= 1'b0;
            while (awaited_rsp.size() != 0)
                @(posedge clk);
            @(posedge clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ((n % 64) >= 16)
                begin
                    while ($urandom_range(99) < idle_pct[phase])
                    begin
                        start <= 1'b0;
                        @(posedge clk);
                    end
                end
                send_beat(random_request(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rstab_pkg.sv
rtl/core/rstab_ram.sv
rtl/core/rstab_ctrl.sv
rtl/core/rstab_dp.sv
rtl/core/reservation_station_table.sv
rtl/core/rstab_checker.sv
sim/tb_top.sv
